// ===== hw/rtl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// shared types, codes and constants of the four-level page walker
// ----------------------------------------------------------------------------
package ptw_pkg;

    // default depth of the local page-table store, in 64-bit words
    localparam int STORE_WORDS_DEF = 4096;

    localparam int ENTRY_W = 64;
    localparam int PADDR_W = 52;
    localparam int VADDR_W = 48;
    localparam int BASE_W  = 40;   // table base, physical address bits 51:12
    localparam int WORD_W  = 49;   // full word index: base plus 9-bit entry index

    // operation codes
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_OUTSIDE     = 2'd2;

    // page size codes
    localparam logic [1:0] SZ_4K = 2'd0;
    localparam logic [1:0] SZ_2M = 2'd1;
    localparam logic [1:0] SZ_1G = 2'd2;

    // walk levels
    localparam logic [1:0] LVL_PT   = 2'd0;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PML4 = 2'd3;

    // entry bit positions
    localparam int BIT_PRESENT = 0;
    localparam int BIT_PS      = 7;

    typedef struct packed {
        logic        operation;
        logic [11:0] word_index;
        logic [63:0] word_data;
        logic [63:0] virtual_address;
    } t_in_item;

    typedef struct packed {
        logic [51:0] physical_address;
        logic [1:0]  page_size;
        logic [1:0]  status;
    } t_out_item;

    // one request to the shared index unit
    typedef struct packed {
        logic [BASE_W-1:0]  base;
        logic [VADDR_W-1:0] va;
        logic [1:0]         level;
    } t_walk_req;

endpackage

// ===== hw/rtl/ptw_ram.sv =====
// ----------------------------------------------------------------------------
// ptw_ram
// generic single-port ram, registered read
// ----------------------------------------------------------------------------
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ptw_index_unit.sv =====
// ----------------------------------------------------------------------------
// ptw_index_unit
// forms the store word index of one table entry and checks it against depth
// ----------------------------------------------------------------------------
module ptw_index_unit #(
    parameter int STORE_WORDS = ptw_pkg::STORE_WORDS_DEF
) (
    input  ptw_pkg::t_walk_req                i_req,
    output logic [$clog2(STORE_WORDS)-1:0]    o_word_addr,
    output logic                              o_outside
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam logic [ptw_pkg::WORD_W-1:0] LIMIT = ptw_pkg::WORD_W'(STORE_WORDS);

    logic [8:0]                   idx;
    logic [ptw_pkg::WORD_W-1:0]   word;

    // pick the 9-bit index field of this level
    always_comb begin
        case (i_req.level)
            ptw_pkg::LVL_PML4: idx = i_req.va[47:39];
            ptw_pkg::LVL_PDPT: idx = i_req.va[38:30];
            ptw_pkg::LVL_PD:   idx = i_req.va[29:21];
            ptw_pkg::LVL_PT:   idx = i_req.va[20:12];
            default:           idx = i_req.va[20:12];
        endcase
    end

    // base is 4 KB aligned, so base/8 + idx is a plain concatenation
    assign word        = {i_req.base, idx};
    assign o_outside   = (word >= LIMIT);
    assign o_word_addr = word[AW-1:0];

endmodule

// ===== hw/rtl/page_table_walk_translate.sv =====
// ----------------------------------------------------------------------------
// page_table_walk_translate
// four-level x86-64 page walker over a local page-table store
// ----------------------------------------------------------------------------
// A write beat stores one 64-bit table word at word_index and returns an
// all-zero result. A translate beat walks the level-4, pointer, directory
// and table levels from root_table_address, stopping early on a 1 GB or
// 2 MB page, a non-present entry or an entry index outside the store, and
// returns the physical address, page size and status. Each level is one
// read of the single-port store, with the next entry address formed from
// the returned word in the same cycle by the shared index unit. The input
// stalls for the whole walk; a finished result sits in the output
// register, and the next item is taken while it waits. The store holds no
// valid bits and needs no clearing pass; reading a word never written
// gives an arbitrary result.
// ----------------------------------------------------------------------------
module page_table_walk_translate #(
    parameter int STORE_WORDS = ptw_pkg::STORE_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // configuration: root table address
    input  logic               i_cfg_we,
    input  logic [51:0]        i_cfg_wdata,

    // item input
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ptw_pkg::t_in_item  i_in,

    // result output
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ptw_pkg::t_out_item o_out
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam int IW = (AW > 12) ? AW : 12;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;   // entry data arriving from store
    localparam logic [1:0] S_DONE = 2'd2;   // result held for a busy output

    logic [1:0]                          r_state, n_state;
    logic [1:0]                          r_level, n_level;
    logic [ptw_pkg::VADDR_W-1:0]         r_va, n_va;
    logic [51:0]                         r_root;
    logic                                r_out_valid, n_out_valid;
    ptw_pkg::t_out_item                  r_out, n_out;
    ptw_pkg::t_out_item                  r_res, n_res;

    logic                                in_accept;
    logic                                out_free;
    logic                                fin;
    ptw_pkg::t_out_item                  fin_res;

    ptw_pkg::t_walk_req                  walk_req;
    logic [AW-1:0]                       walk_addr;
    logic                                walk_outside;

    logic                                ram_we;
    logic [AW-1:0]                       ram_addr;
    logic [ptw_pkg::ENTRY_W-1:0]         rd_data;
    logic [IW-1:0]                       wi_ext;
    logic                                wi_in_range;

    // handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // shared index unit: first level from the root and the incoming address,
    // later levels from the entry just read
    always_comb begin
        if (r_state == S_IDLE) begin
            walk_req.base  = r_root[51:12];
            walk_req.va    = i_in.virtual_address[ptw_pkg::VADDR_W-1:0];
            walk_req.level = ptw_pkg::LVL_PML4;
        end else begin
            walk_req.base  = rd_data[51:12];
            walk_req.va    = r_va;
            walk_req.level = r_level - 2'd1;
        end
    end

    ptw_index_unit #(
        .STORE_WORDS (STORE_WORDS)
    ) u_index (
        .i_req       (walk_req),
        .o_word_addr (walk_addr),
        .o_outside   (walk_outside)
    );

    // table store port: write beats write, otherwise the walk reads
    assign wi_ext      = IW'(i_in.word_index);
    assign wi_in_range = (32'(i_in.word_index) < 32'(STORE_WORDS));
    assign ram_we      = in_accept && (i_in.operation == ptw_pkg::OP_WRITE) && wi_in_range;
    assign ram_addr    = ram_we ? wi_ext[AW-1:0] : walk_addr;

    ptw_ram #(
        .WIDTH (ptw_pkg::ENTRY_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in.word_data),
        .o_rdata (rd_data)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_va        = r_va;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_res       = r_res;
        fin         = 1'b0;
        fin_res     = '0;

        // output drains when taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in.operation == ptw_pkg::OP_WRITE) begin
                        // write done, all-zero result (out of range writes dropped)
                        fin = 1'b1;
                    end else if (walk_outside) begin
                        fin            = 1'b1;
                        fin_res.status = ptw_pkg::ST_OUTSIDE;
                    end else begin
                        // level-4 read issued this cycle
                        n_level = ptw_pkg::LVL_PML4;
                        n_va    = i_in.virtual_address[ptw_pkg::VADDR_W-1:0];
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (!rd_data[ptw_pkg::BIT_PRESENT]) begin
                    fin            = 1'b1;
                    fin_res.status = ptw_pkg::ST_NOT_PRESENT;
                end else if (r_level == ptw_pkg::LVL_PDPT && rd_data[ptw_pkg::BIT_PS]) begin
                    // 1 GB page
                    fin                      = 1'b1;
                    fin_res.physical_address = {rd_data[51:30], r_va[29:0]};
                    fin_res.page_size        = ptw_pkg::SZ_1G;
                end else if (r_level == ptw_pkg::LVL_PD && rd_data[ptw_pkg::BIT_PS]) begin
                    // 2 MB page
                    fin                      = 1'b1;
                    fin_res.physical_address = {rd_data[51:21], r_va[20:0]};
                    fin_res.page_size        = ptw_pkg::SZ_2M;
                end else if (r_level == ptw_pkg::LVL_PT) begin
                    // 4 KB page
                    fin                      = 1'b1;
                    fin_res.physical_address = {rd_data[51:12], r_va[11:0]};
                    fin_res.page_size        = ptw_pkg::SZ_4K;
                end else if (walk_outside) begin
                    fin            = 1'b1;
                    fin_res.status = ptw_pkg::ST_OUTSIDE;
                end else begin
                    // next level read issued this cycle
                    n_level = r_level - 2'd1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // deliver straight to the output register when it is free
        if (fin) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out       = fin_res;
                n_state     = S_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = S_DONE;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_root      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_root <= i_cfg_wdata;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_level <= n_level;
        r_va    <= n_va;
        r_out   <= n_out;
        r_res   <= n_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a failed walk reports no address and no size
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ptw_pkg::ST_OK)
            |-> (o_out.physical_address == '0 && o_out.page_size == ptw_pkg::SZ_4K))
        else $error("failed walk carries address or size");

    // a walk read only follows an accepted translate or another read
    a_read_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(r_state) == S_IDLE || $past(r_state) == S_READ))
        else $error("walk read entered from a wrong state");

    // a held result is only kept while the output register is blocked
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DONE) |-> $past(r_out_valid && i_out_stall))
        else $error("result held although output was free");

    // no page size code beyond 1 GB
    a_size_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.page_size != 2'd3))
        else $error("bad page size code");

endmodule
